[hw/rtl/point_segment_distance_defines.svh]
// Assertion macros shared by the point-to-segment distance RTL.
`ifndef POINT_SEGMENT_DISTANCE_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_DEFINES_SVH

// Checked on every rising edge while out of reset.
`define PSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define PSD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hw/rtl/psd_pkg.sv]
// Types, widths and step functions for the point-to-segment distance pipeline.
`default_nettype none
package psd_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS   = 8;
  localparam int DIST_WIDTH  = 25;

  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int SQ_W   = SUM_W;
  localparam int RAD_W  = SQ_W + 2 * FRAC_BITS + (SQ_W % 2);
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 3;

  localparam logic [DIST_WIDTH-1:0] DIST_MAX = '1;

  typedef enum logic [1:0] {
    CASE_DEGEN    = 2'd0,
    CASE_END_A    = 2'd1,
    CASE_END_B    = 2'd2,
    CASE_INTERIOR = 2'd3
  } case_e;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] p_x;
    logic signed [COORD_WIDTH-1:0] p_y;
    logic signed [COORD_WIDTH-1:0] a_x;
    logic signed [COORD_WIDTH-1:0] a_y;
    logic signed [COORD_WIDTH-1:0] b_x;
    logic signed [COORD_WIDTH-1:0] b_y;
  } psd_in_t;

  typedef struct packed {
    logic [DIST_WIDTH-1:0] distance;
    case_e                 which_case;
  } psd_out_t;

  // front end -> square root
  typedef struct packed {
    logic [SQ_W-1:0] sq;
    logic [SQ_W-1:0] mag;
    case_e           which_case;
  } front_t;

  // square root -> divider
  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic [SQ_W-1:0]   mag;
    case_e             which_case;
  } root_t;

  // divider -> output stage
  typedef struct packed {
    logic [ROOT_W-1:0]     quot;
    logic                  sat;
    logic [DIST_WIDTH-1:0] bypass;
    case_e                 which_case;
  } div_res_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [SQ_W-1:0]   mag;
    case_e             which_case;
  } isq_st_t;

  typedef struct packed {
    logic [ROOT_W-1:0]     rem;
    logic [ROOT_W-1:0]     quot;
    logic [ROOT_W-1:0]     nlo;
    logic [ROOT_W-1:0]     divisor;
    logic                  sat;
    logic [DIST_WIDTH-1:0] bypass;
    case_e                 which_case;
  } div_st_t;

  // one digit of the restoring square root
  function automatic isq_st_t isqrt_step(isq_st_t s);
    isq_st_t          r;
    logic [REM_W-1:0] r2;
    logic [REM_W-1:0] trial;
    r = s;
    r2 = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
    trial = {{(REM_W-ROOT_W-2){1'b0}}, s.root, 2'b01};
    r.rad = s.rad << 2;
    if (r2 >= trial) begin
      r.rem  = r2 - trial;
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = r2;
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // one quotient bit of the restoring divider
  function automatic div_st_t div_step(div_st_t s);
    div_st_t         r;
    logic [ROOT_W:0] r2;
    logic [ROOT_W:0] dd;
    r = s;
    r2 = {s.rem, s.nlo[ROOT_W-1]};
    dd = {1'b0, s.divisor};
    r.nlo = s.nlo << 1;
    if (r2 >= dd) begin
      r.rem  = ROOT_W'(r2 - dd);
      r.quot = {s.quot[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = r2[ROOT_W-1:0];
      r.quot = {s.quot[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/psd_front.sv]
// Front end: differences, products, dot/cross sums and case selection.
`default_nettype none
module psd_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire psd_pkg::psd_in_t req_i,
  output logic                  valid_o,
  output psd_pkg::front_t       data_o
);
  import psd_pkg::*;

  // stage 1: differences
  logic [2:0] v_q;
  logic signed [DIFF_W-1:0] dx_q, dy_q, ux_q, uy_q, vx_q, vy_q;
  logic signed [DIFF_W-1:0] dx_d, dy_d, ux_d, uy_d, vx_d, vy_d;

  assign dx_d = DIFF_W'(req_i.b_x) - DIFF_W'(req_i.a_x);
  assign dy_d = DIFF_W'(req_i.b_y) - DIFF_W'(req_i.a_y);
  assign ux_d = DIFF_W'(req_i.p_x) - DIFF_W'(req_i.a_x);
  assign uy_d = DIFF_W'(req_i.p_y) - DIFF_W'(req_i.a_y);
  assign vx_d = DIFF_W'(req_i.p_x) - DIFF_W'(req_i.b_x);
  assign vy_d = DIFF_W'(req_i.p_y) - DIFF_W'(req_i.b_y);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q <= dx_d; dy_q <= dy_d;
      ux_q <= ux_d; uy_q <= uy_d;
      vx_q <= vx_d; vy_q <= vy_d;
    end
  end

  // stage 2: products, one multiplier deep
  logic signed [PROD_W-1:0] dxux_q, dyuy_q, dxvx_q, dyvy_q, dxuy_q, dyux_q;
  logic signed [PROD_W-1:0] uxux_q, uyuy_q, vxvx_q, vyvy_q, dxdx_q, dydy_q;
  logic                     degen_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dxux_q  <= dx_q * ux_q;
      dyuy_q  <= dy_q * uy_q;
      dxvx_q  <= dx_q * vx_q;
      dyvy_q  <= dy_q * vy_q;
      dxuy_q  <= dx_q * uy_q;
      dyux_q  <= dy_q * ux_q;
      uxux_q  <= ux_q * ux_q;
      uyuy_q  <= uy_q * uy_q;
      vxvx_q  <= vx_q * vx_q;
      vyvy_q  <= vy_q * vy_q;
      dxdx_q  <= dx_q * dx_q;
      dydy_q  <= dy_q * dy_q;
      degen_q <= (dx_q == '0) && (dy_q == '0);
    end
  end

  // stage 3: sums and case pick
  logic signed [SUM_W-1:0] dot_u, dot_v, cross_du;
  logic [SQ_W-1:0]         sq_u, sq_v, sq_d;
  front_t                  data_d, data_q;

  assign dot_u    = SUM_W'(dxux_q) + SUM_W'(dyuy_q);
  assign dot_v    = SUM_W'(dxvx_q) + SUM_W'(dyvy_q);
  assign cross_du = SUM_W'(dxuy_q) - SUM_W'(dyux_q);
  assign sq_u     = SQ_W'(uxux_q) + SQ_W'(uyuy_q);
  assign sq_v     = SQ_W'(vxvx_q) + SQ_W'(vyvy_q);
  assign sq_d     = SQ_W'(dxdx_q) + SQ_W'(dydy_q);

  always_comb begin
    data_d.mag = cross_du[SUM_W-1] ? SQ_W'(-cross_du) : SQ_W'(cross_du);
    priority if (degen_q) begin
      data_d.sq = sq_u; data_d.which_case = CASE_DEGEN;
    end else if (dot_u < 0) begin
      data_d.sq = sq_u; data_d.which_case = CASE_END_A;
    end else if (dot_v > 0) begin
      data_d.sq = sq_v; data_d.which_case = CASE_END_B;
    end else begin
      data_d.sq = sq_d; data_d.which_case = CASE_INTERIOR;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  assign valid_o = v_q[2];
  assign data_o  = data_q;
endmodule
`default_nettype wire

[hw/rtl/psd_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module psd_isqrt (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire psd_pkg::front_t data_i,
  output logic                 valid_o,
  output psd_pkg::root_t       data_o
);
  import psd_pkg::*;

  isq_st_t           st_in [ROOT_W];
  isq_st_t           st_q  [ROOT_W];
  logic [ROOT_W-1:0] v_in;
  logic [ROOT_W-1:0] v_q;

  // radicand is the squared length scaled by 2^(2*FRAC_BITS)
  always_comb begin
    st_in[0].rad        = RAD_W'(data_i.sq) << (2 * FRAC_BITS);
    st_in[0].rem        = '0;
    st_in[0].root       = '0;
    st_in[0].mag        = data_i.mag;
    st_in[0].which_case = data_i.which_case;
  end
  assign v_in[0] = valid_i;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= isqrt_step(st_in[k]);
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in[k];
      end
    end
    if (k < ROOT_W - 1) begin : g_link
      assign st_in[k+1] = st_q[k];
      assign v_in[k+1]  = v_q[k];
    end
  end

  assign valid_o           = v_q[ROOT_W-1];
  assign data_o.root       = st_q[ROOT_W-1].root;
  assign data_o.mag        = st_q[ROOT_W-1].mag;
  assign data_o.which_case = st_q[ROOT_W-1].which_case;
endmodule
`default_nettype wire

[hw/rtl/psd_div.sv]
// Pipelined restoring divider: scaled cross magnitude over segment length.
`default_nettype none
module psd_div (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire psd_pkg::root_t data_i,
  output logic                valid_o,
  output psd_pkg::div_res_t   data_o
);
  import psd_pkg::*;

  // entry stage: scale numerator, overflow check, end-point bypass
  logic [RAD_W-1:0] num;
  div_st_t          ent_d, ent_q;
  logic             ent_v_q;

  assign num = RAD_W'(data_i.mag) << (2 * FRAC_BITS);

  always_comb begin
    ent_d.rem        = num[RAD_W-1 -: ROOT_W];
    ent_d.nlo        = num[ROOT_W-1:0];
    ent_d.quot       = '0;
    ent_d.divisor    = data_i.root;
    ent_d.sat        = num[RAD_W-1 -: ROOT_W] >= data_i.root;
    ent_d.bypass     = (data_i.root > ROOT_W'(DIST_MAX)) ? DIST_MAX
                                                         : data_i.root[DIST_WIDTH-1:0];
    ent_d.which_case = data_i.which_case;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ent_q <= ent_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_v_q <= 1'b0;
    end else if (en_i) begin
      ent_v_q <= valid_i;
    end
  end

  div_st_t           st_in [ROOT_W];
  div_st_t           st_q  [ROOT_W];
  logic [ROOT_W-1:0] v_in;
  logic [ROOT_W-1:0] v_q;

  assign st_in[0] = ent_q;
  assign v_in[0]  = ent_v_q;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= div_step(st_in[k]);
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in[k];
      end
    end
    if (k < ROOT_W - 1) begin : g_link
      assign st_in[k+1] = st_q[k];
      assign v_in[k+1]  = v_q[k];
    end
  end

  assign valid_o           = v_q[ROOT_W-1];
  assign data_o.quot       = st_q[ROOT_W-1].quot;
  assign data_o.sat        = st_q[ROOT_W-1].sat;
  assign data_o.bypass     = st_q[ROOT_W-1].bypass;
  assign data_o.which_case = st_q[ROOT_W-1].which_case;
endmodule
`default_nettype wire

[hw/rtl/point_segment_distance.sv]
// Top level of the point-to-segment distance pipeline.
// Usage notes:
//  - Input channel: in_valid_i / in_stall_o with request in_req_i (P, A, B as
//    signed integer coordinates). A request is taken on a rising edge with
//    in_valid_i high and in_stall_o low.
//  - Output channel: out_valid_o / out_stall_i with request out_req_o
//    (distance with 8 fraction bits, rounded down, and the case code).
//  - Throughput: one request per cycle while no stall is raised, with no
//    bubbles between back-to-back requests.
//  - Pipeline from acceptance to out_valid_o: 3 front-end stages
//    (differences, products, sums), 26 square-root stages (one root bit each),
//    1 divider entry stage, 26 divider stages (one quotient bit each), and the
//    output register. Depth is set by the root and quotient widths.
//  - Every item runs through the same stages; end-point and degenerate cases
//    simply bypass the divider result.
//  - Reset (rst_ni low, asynchronous) clears all stage valid bits; in-flight
//    requests are dropped. The data registers are not reset.
//  - Stall: while the output register holds a request and out_stall_i is
//    high, the whole pipeline freezes and in_stall_o is raised in the same
//    cycle. Nothing is lost or repeated.
`default_nettype none
`include "point_segment_distance_defines.svh"
module point_segment_distance (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire psd_pkg::psd_in_t in_req_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output psd_pkg::psd_out_t     out_req_o
);
  import psd_pkg::*;

  // global advance: free unless a finished request is held by the receiver
  logic     en;
  logic     out_valid_q;
  psd_out_t out_req_q, out_req_d;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  logic     fr_valid;
  front_t   fr_data;
  logic     rt_valid;
  root_t    rt_data;
  logic     dv_valid;
  div_res_t dv_data;

  psd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .req_i   (in_req_i),
    .valid_o (fr_valid),
    .data_o  (fr_data)
  );

  // one root per item: |U|, |V| or |D| depending on the case
  psd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .data_i  (fr_data),
    .valid_o (rt_valid),
    .data_o  (rt_data)
  );

  psd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rt_valid),
    .data_i  (rt_data),
    .valid_o (dv_valid),
    .data_o  (dv_data)
  );

  // interior: clamp quotient; end points and degenerate: clamped root
  always_comb begin
    out_req_d.which_case = dv_data.which_case;
    if (dv_data.which_case == CASE_INTERIOR) begin
      out_req_d.distance = (dv_data.sat || (dv_data.quot > ROOT_W'(DIST_MAX)))
                           ? DIST_MAX : dv_data.quot[DIST_WIDTH-1:0];
    end else begin
      out_req_d.distance = dv_data.bypass;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_req_q <= out_req_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

  `PSD_ASSERT_RST(a_rst_empty, !rst_ni |-> !out_valid_o, "output valid during reset")
  `PSD_ASSERT(a_stall_backs_up, (out_valid_o && out_stall_i) |-> in_stall_o, "stall not passed back")
  `PSD_ASSERT(a_dist_in_range, out_valid_o |-> (out_req_o.distance != DIST_MAX), "distance saturated")
endmodule
`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the point_segment_distance pipeline.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import psd_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 120;   // pipeline is 57 deep
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int RANDOM_ITEMS   = 1330;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b1;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  psd_in_t  in_req_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  psd_out_t out_req_o;

  psd_out_t dist_expected_q[$];
  int       error_count = 0;
  int       idle_cycles = 0;
  bit       burst_mode = 1'b0;   // no gaps on either side while set
  bit       hold_request = 1'b0; // asks the receiver for one long hold-off

  always #2 clk_i = ~clk_i;

  point_segment_distance i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  // floor(sqrt(n)); result stays below 2^32 so the square fits in 64 bits
  function automatic logic [63:0] floor_sqrt(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // Expected distance and case for one request; all intermediates are exact.
  function automatic psd_out_t segment_distance(psd_in_t req);
    longint      dx, dy, ux, uy, vx, vy, cross_p;
    logic [63:0] sq, mag, len, quot;
    psd_out_t    res;
    dx = longint'(req.b_x) - longint'(req.a_x);
    dy = longint'(req.b_y) - longint'(req.a_y);
    ux = longint'(req.p_x) - longint'(req.a_x);
    uy = longint'(req.p_y) - longint'(req.a_y);
    vx = longint'(req.p_x) - longint'(req.b_x);
    vy = longint'(req.p_y) - longint'(req.b_y);
    if (dx == 0 && dy == 0) begin
      sq = ux * ux + uy * uy;
      res.which_case = CASE_DEGEN;
    end else if (dx * ux + dy * uy < 0) begin
      sq = ux * ux + uy * uy;
      res.which_case = CASE_END_A;
    end else if (dx * vx + dy * vy > 0) begin
      sq = vx * vx + vy * vy;
      res.which_case = CASE_END_B;
    end else begin
      res.which_case = CASE_INTERIOR;
    end
    if (res.which_case == CASE_INTERIOR) begin
      cross_p = dx * uy - dy * ux;
      mag  = (cross_p < 0) ? -cross_p : cross_p;
      len  = floor_sqrt((dx * dx + dy * dy) << (2 * FRAC_BITS));
      quot = (mag << (2 * FRAC_BITS)) / len;
    end else begin
      quot = floor_sqrt(sq << (2 * FRAC_BITS));
    end
    res.distance = (quot > DIST_MAX) ? DIST_MAX : quot[DIST_WIDTH-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, psd_out_t got, psd_out_t want);
    $display("mismatch (%s): got dist=%0d case=%0d, want dist=%0d case=%0d",
             what, got.distance, got.which_case, want.distance, want.which_case);
    error_count++;
  endtask

  // Directed table: expected typed only where obvious, else from the predictor
  typedef struct {
    psd_in_t  req;
    bit       typed;
    psd_out_t want;
  } directed_row_t;

  localparam logic signed [15:0] CMAX = 16'sh7fff;
  localparam logic signed [15:0] CMIN = 16'sh8000;

  directed_row_t directed_rows[] = '{
    // all zero: degenerate, zero length
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{25'd0, CASE_DEGEN}},
    // 3-4-5 triangle, degenerate segment
    '{'{16'sd3, 16'sd4, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{25'd1280, CASE_DEGEN}},
    // behind end A
    '{'{-16'sd3, 16'sd4, 16'sd0, 16'sd0, 16'sd10, 16'sd0}, 1'b1, '{25'd1280, CASE_END_A}},
    // past end B
    '{'{16'sd13, 16'sd4, 16'sd0, 16'sd0, 16'sd10, 16'sd0}, 1'b1, '{25'd1280, CASE_END_B}},
    // interior, 7 above the segment
    '{'{16'sd5, 16'sd7, 16'sd0, 16'sd0, 16'sd10, 16'sd0}, 1'b1, '{25'd1792, CASE_INTERIOR}},
    // point exactly on A and on B: dot product zero goes to interior
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd0}, 1'b1, '{25'd0, CASE_INTERIOR}},
    '{'{16'sd10, 16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd0}, 1'b1, '{25'd0, CASE_INTERIOR}},
    // coordinate extremes
    '{'{CMAX, CMAX, CMIN, CMIN, CMIN, CMIN}, 1'b0, '0},
    '{'{CMIN, CMIN, CMAX, CMAX, CMAX, CMAX}, 1'b0, '0},
    '{'{CMAX, CMIN, CMIN, CMIN, CMAX, CMAX}, 1'b0, '0},
    '{'{CMIN, CMAX, CMIN, CMIN, CMAX, CMAX}, 1'b0, '0},
    '{'{CMAX, CMAX, CMIN, CMIN, CMAX, CMIN}, 1'b0, '0},
    '{'{CMIN, CMIN, CMIN, CMAX, CMAX, CMIN}, 1'b0, '0},
    '{'{CMAX, CMIN, CMIN, CMAX, CMIN, CMIN}, 1'b0, '0},
    '{'{16'sd0, 16'sd0, CMIN, CMIN, CMAX, CMAX}, 1'b0, '0},
    '{'{CMAX, CMAX, CMIN, CMAX, CMAX, CMIN}, 1'b0, '0},
    // shortest nonzero segments with a far point, then two short segments
    '{'{CMIN, CMAX, 16'sd0, 16'sd0, 16'sd1, 16'sd0}, 1'b0, '0},
    '{'{16'sd0, CMAX, 16'sd0, 16'sd0, 16'sd0, 16'sd1}, 1'b0, '0},
    '{'{16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd3, 16'sd2}, 1'b0, '0},
    '{'{-16'sd1, 16'sd1, -16'sd1, -16'sd1, 16'sd1, 16'sd1}, 1'b0, '0}
  };

  function automatic logic signed [15:0] rand_coord();
    return 16'($urandom);
  endfunction

  // Random request; mostly near segments so every case is well represented
  function automatic psd_in_t random_request();
    psd_in_t req;
    int      span;
    int      mode;
    mode = $urandom_range(0, 9);
    span = (mode < 5) ? $urandom_range(1, 64) : 32767;
    if (mode >= 8) begin
      // full range on every bit
      req = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(),
              rand_coord(), rand_coord()};
    end else begin
      req.a_x = rand_coord();
      req.a_y = rand_coord();
      req.b_x = req.a_x + 16'($urandom_range(0, 2 * span) - span);
      req.b_y = req.a_y + 16'($urandom_range(0, 2 * span) - span);
      req.p_x = req.a_x + 16'($urandom_range(0, 4 * span) - 2 * span);
      req.p_y = req.a_y + 16'($urandom_range(0, 4 * span) - 2 * span);
      if (mode == 7) begin
        // degenerate segment
        req.b_x = req.a_x;
        req.b_y = req.a_y;
      end
    end
    return req;
  endfunction

  // Offer one request and wait for it to be taken; want is queued on accept.
  task automatic send_request(psd_in_t req, psd_out_t want);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_req_i   = req;
    do @(posedge clk_i); while (in_stall_o);
    dist_expected_q.push_back(want);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (dist_expected_q.size() != 0) @(negedge clk_i);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (dist_expected_q.size() == 0) begin
        report_mismatch("unexpected result", out_req_o, '0);
      end else begin
        psd_out_t want;
        want = dist_expected_q.pop_front();
        if (out_req_o.distance !== want.distance ||
            out_req_o.which_case !== want.which_case)
          report_mismatch("field", out_req_o, want);
      end
    end
  end

  // Receiver: random stall per result, one long hold-off on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      n = burst_mode ? 0 : $urandom_range(0, 19);
      if (hold_request) begin
        n = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (n > 0) begin
        out_stall_i = 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Watchdog: cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stimulus
  initial begin
    psd_in_t req;
    // assert reset after time zero so the flops see a real falling edge
    #1 rst_ni = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed ?
                   directed_rows[i].want : segment_distance(directed_rows[i].req));
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 200 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      // long receiver hold-off while requests keep flowing
      if (i == 300) begin
        burst_mode   = 1'b1;
        hold_request = 1'b1;
      end
      if (i == 500) burst_mode = 1'b0;
      // sender pause until the pipeline is empty
      if (i == 700) wait_drained();
      req = random_request();
      send_request(req, segment_distance(req));
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (error_count == 0 && dist_expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
